### sv/mm9_pkg.sv
// Package for the multichannel median-of-9 ADC filter.
// Opcodes, register indexes, window size and the exchange network table.
package mm9_pkg;
  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int WIN             = 9;
  localparam int NET_LEN         = 19;
  localparam int CAL_BITS        = 12;

  localparam logic [2:0] OP_STORE = 3'd0;
  localparam logic [2:0] OP_RAW   = 3'd1;
  localparam logic [2:0] OP_MV    = 3'd2;
  localparam logic [2:0] OP_TEMP  = 3'd3;
  localparam logic [2:0] OP_VDD   = 3'd4;

  localparam logic [2:0] REG_TCAL_LO = 3'd0;
  localparam logic [2:0] REG_TCAL_HI = 3'd1;
  localparam logic [2:0] REG_VREF    = 3'd2;
  localparam logic [2:0] REG_TCH     = 3'd3;
  localparam logic [2:0] REG_VCH     = 3'd4;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
  } cx_pair_t;

  function automatic cx_pair_t net_pair(input logic [4:0] i);
    cx_pair_t p;
    p = '{4'd0, 4'd0};
    case (i)
      5'd0:  p = '{4'd1, 4'd2};
      5'd1:  p = '{4'd4, 4'd5};
      5'd2:  p = '{4'd7, 4'd8};
      5'd3:  p = '{4'd0, 4'd1};
      5'd4:  p = '{4'd3, 4'd4};
      5'd5:  p = '{4'd6, 4'd7};
      5'd6:  p = '{4'd1, 4'd2};
      5'd7:  p = '{4'd4, 4'd5};
      5'd8:  p = '{4'd7, 4'd8};
      5'd9:  p = '{4'd0, 4'd3};
      5'd10: p = '{4'd5, 4'd8};
      5'd11: p = '{4'd4, 4'd7};
      5'd12: p = '{4'd3, 4'd6};
      5'd13: p = '{4'd1, 4'd4};
      5'd14: p = '{4'd2, 4'd5};
      5'd15: p = '{4'd4, 4'd7};
      5'd16: p = '{4'd4, 4'd2};
      5'd17: p = '{4'd6, 4'd4};
      5'd18: p = '{4'd4, 4'd2};
      default: p = '{4'd0, 4'd0};
    endcase
    return p;
  endfunction
endpackage

### sv/mm9_div.sv
// Restoring divider, one quotient bit per cycle, unsigned 40 by 32 bits.
// Used by the filter core for the temperature and supply conversions.
module mm9_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [39:0] quotient
);
  logic [39:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; dv_nxt = dv_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[39]} - {1'b0, dv_r};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; dv_nxt = divisor;
      cnt_nxt = 6'd40; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt = {q_r[38:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[39]};
        q_nxt = {q_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; dv_r <= dv_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule

### sv/multichannel_median9_adc_filter_core.sv
// Multichannel median-of-9 ADC filter: one shared comparator runs the 19-step
// exchange network, a shared 40-step divider serves temperature and supply.
// Store writes the word in S_PTR. Raw/mV read (S_RD, S_LD), sort (S_CX) and
// scale (S_MUL); temperature and supply then wait on the divider (S_DWAIT).
// in_tready is low while busy or while a result waits for out_tready.
// Reset (rst_n, synchronous) clears the sample memory in a pass through S_CLR.
module multichannel_median9_adc_filter_core import mm9_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // opcode[2:0], channel[5:3], sample[17:6]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // value[31:0], error[32]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int DEPTH = CHANNELS * WIN;
  localparam int AW = $clog2(DEPTH + 1);
  localparam int SB = SAMPLE_BITS;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_LD = 4'd3,
    S_CX = 4'd4, S_MUL = 4'd5, S_TMUL = 4'd6, S_DIV = 4'd7, S_DWAIT = 4'd8,
    S_OUT = 4'd9, S_PTR = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic [SB-1:0] mem [DEPTH];
  logic [SB-1:0] rd_r;
  logic [3:0] ptr_r [CHANNELS];
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [4:0] step_r, step_nxt;
  logic [SB-1:0] w_r [WIN];
  logic [2:0] op_r;
  logic [3:0] qch_r;
  logic [SB-1:0] smp_r;
  logic [11:0] tlo_r, thi_r, vref_r;
  logic [2:0] tch_r, vch_r;
  logic signed [31:0] val_r;
  logic err_r, neg_r;
  logic ovalid_r;
  logic [39:0] dvd_r;
  logic [31:0] dvs_r;
  logic div_start;
  logic div_done;
  logic [39:0] div_q;

  logic in_acc, cfg_wr;
  logic [2:0] in_op, in_ch;
  logic [AW-1:0] base;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [SB-1:0] mem_wd;
  cx_pair_t pr;
  logic [SB-1:0] m;
  logic signed [13:0] d;
  logic signed [40:0] num;

  assign in_op = in_tdata[2:0];
  assign in_ch = in_tdata[5:3];
  assign in_tready = (st_r == S_IDLE) && !ovalid_r;
  assign in_acc = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign base = AW'(qch_r * WIN);
  assign pr = net_pair(step_r);
  assign m = w_r[4];
  assign d = $signed({2'b0, tlo_r}) - $signed({2'b0, thi_r});
  assign out_tvalid = ovalid_r;
  assign out_tdata = {7'd0, err_r, val_r};

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_TCAL_LO: cfg_prdata = {20'd0, tlo_r};
      REG_TCAL_HI: cfg_prdata = {20'd0, thi_r};
      REG_VREF:    cfg_prdata = {20'd0, vref_r};
      REG_TCH:     cfg_prdata = {29'd0, tch_r};
      REG_VCH:     cfg_prdata = {29'd0, vch_r};
      default:     cfg_prdata = '0;
    endcase
  end

  always_comb begin
    mem_we = 1'b0; mem_wa = cnt_r; mem_wd = '0;
    if (st_r == S_CLR) mem_we = 1'b1;
    else if (st_r == S_PTR && {1'b0, qch_r} < 5'(CHANNELS)) begin
      mem_we = 1'b1;
      mem_wa = base + AW'(ptr_r[qch_r[CW-1:0]] >= 4'd9 ? 4'd0
               : ptr_r[qch_r[CW-1:0]]);
      mem_wd = smp_r;
    end
    mem_ra = base + cnt_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  assign num = 41'(($signed({29'd0, tlo_r}) - $signed({29'd0, m})) * 80000)
               + 41'(30000 * d);

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; step_nxt = step_r; div_start = 1'b0;
    unique case (st_r)
      S_CLR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == AW'(DEPTH - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        cnt_nxt = '0; step_nxt = '0;
        if (in_acc) begin
          if (in_op == OP_STORE) st_nxt = S_PTR;
          else if (in_op == OP_RAW || in_op == OP_MV || in_op == OP_TEMP
                   || in_op == OP_VDD) st_nxt = S_RD;
        end
      end
      S_PTR: st_nxt = S_IDLE;
      S_RD: begin
        if ({1'b0, qch_r} >= 5'(CHANNELS)) st_nxt = S_OUT;
        else st_nxt = S_LD;
        cnt_nxt = cnt_r + 1'b1;
      end
      S_LD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == AW'(WIN)) st_nxt = S_CX;
      end
      S_CX: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(NET_LEN - 1)) st_nxt = S_MUL;
      end
      S_MUL: begin
        if (op_r == OP_TEMP) st_nxt = (d == 0) ? S_OUT : S_TMUL;
        else if (op_r == OP_VDD) st_nxt = (m == 0) ? S_OUT : S_DIV;
        else st_nxt = S_OUT;
      end
      S_TMUL: st_nxt = S_DIV;
      S_DIV: begin div_start = 1'b1; st_nxt = S_DWAIT; end
      S_DWAIT: if (div_done) st_nxt = S_OUT;
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; cnt_r <= '0; step_r <= '0; ovalid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) ptr_r[i] <= '0;
      tlo_r <= '0; thi_r <= '0; vref_r <= '0; tch_r <= 3'd4; vch_r <= 3'd5;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; step_r <= step_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[4:2])
          REG_TCAL_LO: tlo_r <= cfg_pwdata[11:0];
          REG_TCAL_HI: thi_r <= cfg_pwdata[11:0];
          REG_VREF:    vref_r <= cfg_pwdata[11:0];
          REG_TCH:     tch_r <= cfg_pwdata[2:0];
          REG_VCH:     vch_r <= cfg_pwdata[2:0];
          default: ;
        endcase
      end
      if (st_r == S_PTR && {1'b0, qch_r} < 5'(CHANNELS)) begin
        ptr_r[qch_r[CW-1:0]] <=
          (ptr_r[qch_r[CW-1:0]] >= 4'd8) ? 4'd0
          : ptr_r[qch_r[CW-1:0]] + 4'd1;
      end
      if (st_r == S_OUT) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_op;
      smp_r <= SB'(in_tdata[17:6]);
      qch_r <= (in_op == OP_TEMP) ? {1'b0, tch_r}
             : (in_op == OP_VDD) ? {1'b0, vch_r} : {1'b0, in_ch};
      val_r <= '0; err_r <= 1'b0;
    end
    if (st_r == S_LD) w_r[cnt_r[3:0] - 4'd1] <= rd_r;
    if (st_r == S_CX && w_r[pr.a] > w_r[pr.b]) begin
      w_r[pr.a] <= w_r[pr.b];
      w_r[pr.b] <= w_r[pr.a];
    end
    if (st_r == S_MUL) begin
      if (op_r == OP_RAW) val_r <= 32'(m);
      else if (op_r == OP_MV) val_r <= 32'((48'(m) * 48'd3300) >> SB);
      else if (op_r == OP_TEMP && d == 0) err_r <= 1'b1;
      else if (op_r == OP_VDD) begin
        if (m == 0) err_r <= 1'b1;
        dvd_r <= 40'(vref_r) * 40'd3300;
        dvs_r <= 32'(m);
      end
    end
    if (st_r == S_TMUL) begin
      neg_r <= num[40] ^ d[13];
      dvd_r <= num[40] ? 40'(-num) : num[39:0];
      dvs_r <= d[13] ? 32'(-d) : 32'(d);
    end
    if (st_r == S_DWAIT && div_done) begin
      if (op_r == OP_VDD) val_r <= div_q[31:0];
      else if (!neg_r) val_r <= (div_q > 40'h7FFFFFFF) ? 32'h7FFFFFFF : div_q[31:0];
      else val_r <= (div_q > 40'h80000000) ? 32'h80000000 : 32'(-div_q);
    end
  end

  mm9_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_r),
    .divisor(dvs_r), .done(div_done), .quotient(div_q)
  );
endmodule
